// ===== sv/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared constants, codes and control types of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package acm_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int ALPHABET   = 26;
	localparam int COUNT_BITS = 16;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int USED_W     = NODE_W + 1;
	localparam int SYM_W      = 5;
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;
	localparam int TOTAL_W    = 32;
	localparam int TDEPTH     = MAX_NODES * ALPHABET;
	localparam int TADDR_W    = $clog2(TDEPTH);
	localparam int CMD_W      = 5;

	localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
	localparam logic [OP_W-1:0] OP_END_PATTERN = 3'd1;
	localparam logic [OP_W-1:0] OP_BUILD       = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY       = 3'd3;
	localparam logic [OP_W-1:0] OP_END_QUERY   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_NONE     = 5'd0;
	localparam logic [CMD_W-1:0] CMD_LATCH    = 5'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_INIT = 5'd2;
	localparam logic [CMD_W-1:0] CMD_CLR_STEP = 5'd3;
	localparam logic [CMD_W-1:0] CMD_CLR_DONE = 5'd4;
	localparam logic [CMD_W-1:0] CMD_INS_RD   = 5'd5;
	localparam logic [CMD_W-1:0] CMD_INS_WR   = 5'd6;
	localparam logic [CMD_W-1:0] CMD_EP_RD    = 5'd7;
	localparam logic [CMD_W-1:0] CMD_EP_WR    = 5'd8;
	localparam logic [CMD_W-1:0] CMD_EP_OVF   = 5'd9;
	localparam logic [CMD_W-1:0] CMD_BLD_INIT = 5'd10;
	localparam logic [CMD_W-1:0] CMD_BR_RD    = 5'd11;
	localparam logic [CMD_W-1:0] CMD_BR_WR    = 5'd12;
	localparam logic [CMD_W-1:0] CMD_BQ_RD    = 5'd13;
	localparam logic [CMD_W-1:0] CMD_BF_RD    = 5'd14;
	localparam logic [CMD_W-1:0] CMD_BF_LAT   = 5'd15;
	localparam logic [CMD_W-1:0] CMD_BT_RD    = 5'd16;
	localparam logic [CMD_W-1:0] CMD_BT_WR    = 5'd17;
	localparam logic [CMD_W-1:0] CMD_BLD_DONE = 5'd18;
	localparam logic [CMD_W-1:0] CMD_Q_RD     = 5'd19;
	localparam logic [CMD_W-1:0] CMD_Q_SET    = 5'd20;
	localparam logic [CMD_W-1:0] CMD_W_RD     = 5'd21;
	localparam logic [CMD_W-1:0] CMD_W_CHK    = 5'd22;
	localparam logic [CMD_W-1:0] CMD_RESULT   = 5'd23;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic             set_st;
		logic [ST_W-1:0]  st;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            sym_ok;
		logic            built;
		logic            ovf;
		logic            c_last;
		logic            clr_last;
		logic            bfs_more;
		logic            walk_stop;
		logic            out_free;
	} stat_t;

	function automatic logic [TADDR_W-1:0] taddr(input logic [NODE_W-1:0] node,
		input logic [SYM_W-1:0] sym);
		return TADDR_W'(node) * TADDR_W'(ALPHABET) + TADDR_W'(sym);
	endfunction

endpackage

// ===== sv/acm_req_if.sv =====
// ----------------------------------------------------------------------------
// acm_req_if
// Request channel: one operation word with its symbol.
// ----------------------------------------------------------------------------
interface acm_req_if;
	logic                        valid;
	logic                        ready;
	logic [acm_pkg::OP_W-1:0]    operation;
	logic [acm_pkg::SYM_W-1:0]   symbol;

	modport source (output valid, output operation, output symbol, input ready);
	modport sink (input valid, input operation, input symbol, output ready);
endinterface

// ===== sv/acm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// acm_rsp_if
// Response channel: status, running total and current node of one word.
// ----------------------------------------------------------------------------
interface acm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [acm_pkg::ST_W-1:0]     status;
	logic [acm_pkg::TOTAL_W-1:0]  match_total;
	logic [acm_pkg::NODE_W-1:0]   current_node;

	modport source (output valid, output status, output match_total, output current_node,
		input ready);
	modport sink (input valid, input status, input match_total, input current_node,
		output ready);
endinterface

// ===== sv/acm_dpath.sv =====
// ----------------------------------------------------------------------------
// acm_dpath
// Node stores, build queue, cursors, totals and the response register.
// ----------------------------------------------------------------------------
module acm_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acm_pkg::cmd_t                 cmd,
	output acm_pkg::stat_t                stat,
	input  logic [acm_pkg::OP_W-1:0]      operation,
	input  logic [acm_pkg::SYM_W-1:0]     symbol,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [acm_pkg::ST_W-1:0]      rsp_status,
	output logic [acm_pkg::TOTAL_W-1:0]   rsp_total,
	output logic [acm_pkg::NODE_W-1:0]    rsp_node
);

	logic [acm_pkg::NODE_W-1:0]     trans_mem [acm_pkg::TDEPTH];
	logic [acm_pkg::NODE_W-1:0]     fail_mem  [acm_pkg::MAX_NODES];
	logic [acm_pkg::COUNT_BITS-1:0] pc_mem    [acm_pkg::MAX_NODES];
	logic                           vis_mem   [acm_pkg::MAX_NODES];
	logic [acm_pkg::NODE_W-1:0]     bq_mem    [acm_pkg::MAX_NODES];

	logic [acm_pkg::NODE_W-1:0]     trans_rd_a, trans_rd_b, fail_rd, bq_rd;
	logic [acm_pkg::COUNT_BITS-1:0] pc_rd;
	logic                           vis_rd;

	logic [acm_pkg::OP_W-1:0]    op_q;
	logic [acm_pkg::SYM_W-1:0]   sym_q, c_q;
	logic [acm_pkg::ST_W-1:0]    st_q;
	logic                        built_q, ovf_q;
	logic [acm_pkg::USED_W-1:0]  used_q, head_q, tail_q;
	logic [acm_pkg::NODE_W-1:0]  ic_q, qc_q, u_q, f_q, i_q;
	logic [acm_pkg::TOTAL_W-1:0] total_q;
	logic [acm_pkg::TADDR_W-1:0] clr_q;

	logic                          out_valid_q;
	logic [acm_pkg::ST_W-1:0]      out_st_q;
	logic [acm_pkg::TOTAL_W-1:0]   out_total_q;
	logic [acm_pkg::NODE_W-1:0]    out_node_q;

	logic [acm_pkg::TADDR_W-1:0]   trans_ra, trans_rb, trans_wa;
	logic [acm_pkg::NODE_W-1:0]    trans_wd, fail_ra, fail_wa, fail_wd, pc_ra, pc_wa;
	logic [acm_pkg::NODE_W-1:0]    vis_wa;
	logic [acm_pkg::COUNT_BITS-1:0] pc_wd;
	logic                          trans_we, fail_we, pc_we, vis_we, vis_wd, bq_we;
	logic                          clr_low, tail_room, ins_new;
	logic [acm_pkg::TOTAL_W:0]     sum;
	logic [acm_pkg::NODE_W-1:0]    node_out;

	assign clr_low   = clr_q < acm_pkg::TADDR_W'(acm_pkg::MAX_NODES);
	assign tail_room = tail_q < acm_pkg::USED_W'(acm_pkg::MAX_NODES);
	assign ins_new   = used_q < acm_pkg::USED_W'(acm_pkg::MAX_NODES);
	assign sum       = {1'b0, total_q} + (acm_pkg::TOTAL_W + 1)'(pc_rd);
	assign node_out  = built_q ? ((op_q == acm_pkg::OP_END_QUERY) ? '0 : qc_q) : ic_q;

	always_comb begin
		trans_ra = acm_pkg::taddr(u_q, c_q);
		case (cmd.code)
			acm_pkg::CMD_INS_RD: trans_ra = acm_pkg::taddr(ic_q, sym_q);
			acm_pkg::CMD_Q_RD:   trans_ra = acm_pkg::taddr(qc_q, sym_q);
			acm_pkg::CMD_BR_RD:  trans_ra = acm_pkg::taddr('0, c_q);
			default:             trans_ra = acm_pkg::taddr(u_q, c_q);
		endcase
		trans_rb = acm_pkg::taddr(f_q, c_q);
		fail_ra  = (cmd.code == acm_pkg::CMD_BF_RD) ? bq_rd : i_q;
		pc_ra    = (cmd.code == acm_pkg::CMD_EP_RD) ? ic_q : i_q;

		trans_we = 1'b0;
		trans_wa = clr_q;
		trans_wd = '0;
		fail_we  = 1'b0;
		fail_wa  = clr_q[acm_pkg::NODE_W-1:0];
		fail_wd  = '0;
		pc_we    = 1'b0;
		pc_wa    = clr_q[acm_pkg::NODE_W-1:0];
		pc_wd    = '0;
		vis_we   = 1'b0;
		vis_wa   = clr_q[acm_pkg::NODE_W-1:0];
		vis_wd   = 1'b0;
		bq_we    = 1'b0;
		case (cmd.code)
			acm_pkg::CMD_CLR_STEP: begin
				trans_we = 1'b1;
				fail_we  = clr_low;
				pc_we    = clr_low;
				vis_we   = clr_low;
			end
			acm_pkg::CMD_INS_WR: begin
				trans_we = (trans_rd_a == '0) && ins_new;
				trans_wa = acm_pkg::taddr(ic_q, sym_q);
				trans_wd = used_q[acm_pkg::NODE_W-1:0];
			end
			acm_pkg::CMD_EP_WR: begin
				pc_we = 1'b1;
				pc_wa = ic_q;
				pc_wd = (pc_rd == acm_pkg::COUNT_MAX) ? pc_rd : pc_rd + 1'b1;
			end
			acm_pkg::CMD_BR_WR: begin
				bq_we = (trans_rd_a != '0) && tail_room;
			end
			acm_pkg::CMD_BT_WR: begin
				bq_we    = (trans_rd_a != '0) && tail_room;
				fail_we  = trans_rd_a != '0;
				fail_wa  = trans_rd_a;
				fail_wd  = trans_rd_b;
				trans_we = trans_rd_a == '0;
				trans_wa = acm_pkg::taddr(u_q, c_q);
				trans_wd = trans_rd_b;
			end
			acm_pkg::CMD_W_CHK: begin
				vis_we = !vis_rd;
				vis_wa = i_q;
				vis_wd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (trans_we) trans_mem[trans_wa] <= trans_wd;
		trans_rd_a <= trans_mem[trans_ra];
		trans_rd_b <= trans_mem[trans_rb];
	end

	always_ff @(posedge clk) begin
		if (fail_we) fail_mem[fail_wa] <= fail_wd;
		fail_rd <= fail_mem[fail_ra];
	end

	always_ff @(posedge clk) begin
		if (pc_we) pc_mem[pc_wa] <= pc_wd;
		pc_rd <= pc_mem[pc_ra];
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd <= vis_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (bq_we) bq_mem[tail_q[acm_pkg::NODE_W-1:0]] <= trans_rd_a;
		bq_rd <= bq_mem[head_q[acm_pkg::NODE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.code == acm_pkg::CMD_LATCH) begin
			op_q  <= operation;
			sym_q <= symbol;
		end
		if (cmd.code == acm_pkg::CMD_BF_RD) u_q <= bq_rd;
		if (cmd.code == acm_pkg::CMD_BF_LAT) f_q <= fail_rd;
		if (cmd.code == acm_pkg::CMD_Q_SET) i_q <= trans_rd_a;
		if (cmd.code == acm_pkg::CMD_W_CHK && !vis_rd) i_q <= fail_rd;
		if (cmd.code == acm_pkg::CMD_RESULT) begin
			out_st_q    <= st_q;
			out_total_q <= total_q;
			out_node_q  <= node_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= acm_pkg::ST_OK;
			built_q     <= 1'b0;
			ovf_q       <= 1'b0;
			used_q      <= acm_pkg::USED_W'(1);
			ic_q        <= '0;
			qc_q        <= '0;
			total_q     <= '0;
			c_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.code != acm_pkg::CMD_RESULT && rsp_valid && rsp_ready)
				out_valid_q <= 1'b0;
			if (cmd.set_st) st_q <= cmd.st;
			case (cmd.code)
				acm_pkg::CMD_LATCH:    st_q <= acm_pkg::ST_OK;
				acm_pkg::CMD_CLR_INIT: clr_q <= '0;
				acm_pkg::CMD_CLR_STEP: clr_q <= clr_q + 1'b1;
				acm_pkg::CMD_CLR_DONE: begin
					built_q <= 1'b0;
					ovf_q   <= 1'b0;
					used_q  <= acm_pkg::USED_W'(1);
					ic_q    <= '0;
					qc_q    <= '0;
					total_q <= '0;
				end
				acm_pkg::CMD_INS_WR: begin
					if (trans_rd_a != '0) begin
						ic_q <= trans_rd_a;
					end else if (ins_new) begin
						ic_q   <= used_q[acm_pkg::NODE_W-1:0];
						used_q <= used_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
						st_q  <= acm_pkg::ST_FULL;
					end
				end
				acm_pkg::CMD_EP_WR: ic_q <= '0;
				acm_pkg::CMD_EP_OVF: begin
					ovf_q <= 1'b0;
					ic_q  <= '0;
				end
				acm_pkg::CMD_BLD_INIT: begin
					c_q    <= '0;
					head_q <= '0;
					tail_q <= '0;
				end
				acm_pkg::CMD_BR_WR: begin
					c_q <= c_q + 1'b1;
					if (bq_we) tail_q <= tail_q + 1'b1;
				end
				acm_pkg::CMD_BQ_RD:  head_q <= head_q + 1'b1;
				acm_pkg::CMD_BF_LAT: c_q <= '0;
				acm_pkg::CMD_BT_WR: begin
					c_q <= c_q + 1'b1;
					if (bq_we) tail_q <= tail_q + 1'b1;
				end
				acm_pkg::CMD_BLD_DONE: begin
					built_q <= 1'b1;
					qc_q    <= '0;
				end
				acm_pkg::CMD_Q_SET: qc_q <= trans_rd_a;
				acm_pkg::CMD_W_CHK: begin
					if (!vis_rd)
						total_q <= sum[acm_pkg::TOTAL_W] ? '1 : sum[acm_pkg::TOTAL_W-1:0];
				end
				acm_pkg::CMD_RESULT: begin
					out_valid_q <= 1'b1;
					if (op_q == acm_pkg::OP_END_QUERY && built_q) begin
						qc_q    <= '0;
						total_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.op        = op_q;
	assign stat.sym_ok    = sym_q < acm_pkg::SYM_W'(acm_pkg::ALPHABET);
	assign stat.built     = built_q;
	assign stat.ovf       = ovf_q;
	assign stat.c_last    = c_q == acm_pkg::SYM_W'(acm_pkg::ALPHABET - 1);
	assign stat.clr_last  = clr_q == acm_pkg::TADDR_W'(acm_pkg::TDEPTH - 1);
	assign stat.bfs_more  = head_q < tail_q;
	assign stat.walk_stop = vis_rd || (i_q == '0);
	assign stat.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_st_q;
	assign rsp_total  = out_total_q;
	assign rsp_node   = out_node_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.code == acm_pkg::CMD_RESULT |-> (!out_valid_q || rsp_ready))
		else $error("response loaded over an untaken word");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("build queue head passed tail");
	a_built_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(cmd.code == acm_pkg::CMD_BLD_DONE))
		else $error("built flag set outside build");
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= acm_pkg::USED_W'(acm_pkg::MAX_NODES))
		else $error("node count beyond store");

endmodule

// ===== sv/acm_ctrl.sv =====
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer for insert, build, query, clear and response hand-off.
// ----------------------------------------------------------------------------
module acm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  acm_pkg::stat_t  stat,
	output acm_pkg::cmd_t   cmd
);

	localparam logic [4:0] S_CLEAR   = 5'd0;
	localparam logic [4:0] S_CLR_END = 5'd1;
	localparam logic [4:0] S_IDLE    = 5'd2;
	localparam logic [4:0] S_DISP    = 5'd3;
	localparam logic [4:0] S_INS_WR  = 5'd4;
	localparam logic [4:0] S_EP_WR   = 5'd5;
	localparam logic [4:0] S_BR_RD   = 5'd6;
	localparam logic [4:0] S_BR_WR   = 5'd7;
	localparam logic [4:0] S_BQ_CHK  = 5'd8;
	localparam logic [4:0] S_BF_RD   = 5'd9;
	localparam logic [4:0] S_BF_LAT  = 5'd10;
	localparam logic [4:0] S_BT_RD   = 5'd11;
	localparam logic [4:0] S_BT_WR   = 5'd12;
	localparam logic [4:0] S_Q_SET   = 5'd13;
	localparam logic [4:0] S_W_RD    = 5'd14;
	localparam logic [4:0] S_W_CHK   = 5'd15;
	localparam logic [4:0] S_RESULT  = 5'd16;

	logic [4:0] state_q, state_d;
	logic       clr_item_q, clr_item_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_d    = state_q;
		clr_item_d = clr_item_q;
		cmd.code   = acm_pkg::CMD_NONE;
		cmd.set_st = 1'b0;
		cmd.st     = acm_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.code = acm_pkg::CMD_CLR_STEP;
				if (stat.clr_last) state_d = S_CLR_END;
			end
			S_CLR_END: begin
				cmd.code   = acm_pkg::CMD_CLR_DONE;
				state_d    = clr_item_q ? S_RESULT : S_IDLE;
				clr_item_d = 1'b0;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = acm_pkg::CMD_LATCH;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_RESULT;
				cmd.st  = acm_pkg::ST_REJECT;
				case (stat.op)
					acm_pkg::OP_INSERT: begin
						if (stat.built || !stat.sym_ok) begin
							cmd.set_st = 1'b1;
						end else if (stat.ovf) begin
							cmd.set_st = 1'b1;
							cmd.st     = acm_pkg::ST_FULL;
						end else begin
							cmd.code = acm_pkg::CMD_INS_RD;
							state_d  = S_INS_WR;
						end
					end
					acm_pkg::OP_END_PATTERN: begin
						if (stat.built) begin
							cmd.set_st = 1'b1;
						end else if (stat.ovf) begin
							cmd.code   = acm_pkg::CMD_EP_OVF;
							cmd.set_st = 1'b1;
							cmd.st     = acm_pkg::ST_FULL;
						end else begin
							cmd.code = acm_pkg::CMD_EP_RD;
							state_d  = S_EP_WR;
						end
					end
					acm_pkg::OP_BUILD: begin
						if (stat.built) begin
							cmd.set_st = 1'b1;
						end else begin
							cmd.code = acm_pkg::CMD_BLD_INIT;
							state_d  = S_BR_RD;
						end
					end
					acm_pkg::OP_QUERY: begin
						if (!stat.built || !stat.sym_ok) begin
							cmd.set_st = 1'b1;
						end else begin
							cmd.code = acm_pkg::CMD_Q_RD;
							state_d  = S_Q_SET;
						end
					end
					acm_pkg::OP_END_QUERY: begin
						cmd.set_st = !stat.built;
					end
					acm_pkg::OP_CLEAR: begin
						cmd.code   = acm_pkg::CMD_CLR_INIT;
						clr_item_d = 1'b1;
						state_d    = S_CLEAR;
					end
					default: cmd.set_st = 1'b1;
				endcase
			end
			S_INS_WR: begin
				cmd.code = acm_pkg::CMD_INS_WR;
				state_d  = S_RESULT;
			end
			S_EP_WR: begin
				cmd.code = acm_pkg::CMD_EP_WR;
				state_d  = S_RESULT;
			end
			S_BR_RD: begin
				cmd.code = acm_pkg::CMD_BR_RD;
				state_d  = S_BR_WR;
			end
			S_BR_WR: begin
				cmd.code = acm_pkg::CMD_BR_WR;
				state_d  = stat.c_last ? S_BQ_CHK : S_BR_RD;
			end
			S_BQ_CHK: begin
				if (stat.bfs_more) begin
					cmd.code = acm_pkg::CMD_BQ_RD;
					state_d  = S_BF_RD;
				end else begin
					cmd.code = acm_pkg::CMD_BLD_DONE;
					state_d  = S_RESULT;
				end
			end
			S_BF_RD: begin
				cmd.code = acm_pkg::CMD_BF_RD;
				state_d  = S_BF_LAT;
			end
			S_BF_LAT: begin
				cmd.code = acm_pkg::CMD_BF_LAT;
				state_d  = S_BT_RD;
			end
			S_BT_RD: begin
				cmd.code = acm_pkg::CMD_BT_RD;
				state_d  = S_BT_WR;
			end
			S_BT_WR: begin
				cmd.code = acm_pkg::CMD_BT_WR;
				state_d  = stat.c_last ? S_BQ_CHK : S_BT_RD;
			end
			S_Q_SET: begin
				cmd.code = acm_pkg::CMD_Q_SET;
				state_d  = S_W_RD;
			end
			S_W_RD: begin
				cmd.code = acm_pkg::CMD_W_RD;
				state_d  = S_W_CHK;
			end
			S_W_CHK: begin
				cmd.code = acm_pkg::CMD_W_CHK;
				state_d  = stat.walk_stop ? S_RESULT : S_W_RD;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.code = acm_pkg::CMD_RESULT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_item_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_item_q <= clr_item_d;
		end
	end

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> state_q == S_DISP)
		else $error("accepted word not dispatched");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && stat.out_free) |=> state_q == S_IDLE)
		else $error("response hand-off did not return to idle");
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_CHK && stat.walk_stop) |=> state_q == S_RESULT)
		else $error("match walk ran past its stop");

endmodule

// ===== sv/aho_corasick_matcher_core.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_matcher_core
// Multi-pattern matcher: trie load, fail-link build, streaming query.
//
//   channel  dir  fields
//   req      in   operation[2:0], symbol[4:0]
//   rsp      out  status[1:0], match_total[31:0], current_node[9:0]
//
// Insert and end pattern each read a store, then write it; end query and rejected
// words go from dispatch straight to the result step. Query follows one transition,
// then walks the fail chain node by node. Build sweeps 26 symbols of each trie node.
// Reset sweeps the 26624-entry transition store, and so does a clear word.
// A waiting response holds the next word in its final step only.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_core (
	input  logic      clk,
	input  logic      arst_n,
	acm_req_if.sink   req,
	acm_rsp_if.source rsp
);

	acm_pkg::cmd_t  cmd;
	acm_pkg::stat_t stat;

	acm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	acm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (req.operation),
		.symbol     (req.symbol),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_total  (rsp.match_total),
		.rsp_node   (rsp.current_node)
	);

endmodule

// ===== tb/acm_checker.sv =====
// ----------------------------------------------------------------------------
// acm_checker
// Watches the request and response channels of the matcher, keeps its own
// trie, fail links and visit marks, predicts the response of every accepted
// word and compares it field by field with the response that comes out.
// ----------------------------------------------------------------------------
module acm_checker (
	input  logic clk,
	input  logic arst_n,
	acm_req_if   req,
	acm_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [acm_pkg::ST_W-1:0]    status;
		logic [acm_pkg::TOTAL_W-1:0] total;
		logic [acm_pkg::NODE_W-1:0]  node;
	} resp_t;

	logic [acm_pkg::NODE_W-1:0]     trans [0:acm_pkg::TDEPTH-1];
	logic [acm_pkg::NODE_W-1:0]     fail [0:acm_pkg::MAX_NODES-1];
	logic [acm_pkg::COUNT_BITS-1:0] pcount [0:acm_pkg::MAX_NODES-1];
	logic                           seen [0:acm_pkg::MAX_NODES-1];
	logic [acm_pkg::NODE_W-1:0]     bfsq [0:acm_pkg::MAX_NODES-1];
	logic [acm_pkg::USED_W-1:0]     used;
	logic [acm_pkg::NODE_W-1:0]     icur;
	logic                           ovf;
	logic [acm_pkg::NODE_W-1:0]     qcur;
	logic [acm_pkg::TOTAL_W-1:0]    total;
	logic                           built;

	resp_t expected_q [$];

	function automatic void clear_trie();
		for (int k = 0; k < acm_pkg::TDEPTH; k++) trans[k] = '0;
		for (int k = 0; k < acm_pkg::MAX_NODES; k++) begin
			fail[k] = '0;
			pcount[k] = '0;
			seen[k] = 1'b0;
			bfsq[k] = '0;
		end
		used = acm_pkg::USED_W'(1);
		icur = '0;
		ovf = 1'b0;
		qcur = '0;
		total = '0;
		built = 1'b0;
	endfunction

	function automatic void build_links();
		int head;
		int tail;
		logic [acm_pkg::NODE_W-1:0] u;
		logic [acm_pkg::NODE_W-1:0] f;
		logic [acm_pkg::NODE_W-1:0] v;
		logic [acm_pkg::NODE_W-1:0] via;
		head = 0;
		tail = 0;
		for (int c = 0; c < acm_pkg::ALPHABET; c++) begin
			v = trans[c];
			if (v != 0 && tail < acm_pkg::MAX_NODES) begin
				fail[v] = '0;
				bfsq[tail] = v;
				tail++;
			end
		end
		while (head < tail) begin
			u = bfsq[head];
			head++;
			f = fail[u];
			for (int c = 0; c < acm_pkg::ALPHABET; c++) begin
				v = trans[int'(u) * acm_pkg::ALPHABET + c];
				via = trans[int'(f) * acm_pkg::ALPHABET + c];
				if (v != 0) begin
					fail[v] = via;
					if (tail < acm_pkg::MAX_NODES) begin
						bfsq[tail] = v;
						tail++;
					end
				end else begin
					trans[int'(u) * acm_pkg::ALPHABET + c] = via;
				end
			end
		end
	endfunction

	function automatic void walk_chain(input logic [acm_pkg::NODE_W-1:0] start);
		logic [acm_pkg::NODE_W-1:0] i;
		logic [acm_pkg::TOTAL_W:0] s;
		i = start;
		for (int steps = 0; steps < acm_pkg::MAX_NODES; steps++) begin
			if (seen[i]) break;
			s = {1'b0, total} + (acm_pkg::TOTAL_W+1)'(pcount[i]);
			total = s[acm_pkg::TOTAL_W] ? '1 : s[acm_pkg::TOTAL_W-1:0];
			seen[i] = 1'b1;
			if (i == 0) break;
			i = fail[i];
		end
	endfunction

	function automatic resp_t match_step(input logic [acm_pkg::OP_W-1:0] op,
		input logic [acm_pkg::SYM_W-1:0] sym);
		resp_t r;
		int k;
		logic [acm_pkg::NODE_W-1:0] v;
		r.status = acm_pkg::ST_OK;
		case (op)
			acm_pkg::OP_INSERT: begin
				if (built || sym >= acm_pkg::ALPHABET) begin
					r.status = acm_pkg::ST_REJECT;
				end else if (ovf) begin
					r.status = acm_pkg::ST_FULL;
				end else begin
					k = int'(icur) * acm_pkg::ALPHABET + int'(sym);
					v = trans[k];
					if (v != 0) begin
						icur = v;
					end else if (used < acm_pkg::MAX_NODES) begin
						trans[k] = used[acm_pkg::NODE_W-1:0];
						icur = used[acm_pkg::NODE_W-1:0];
						used++;
					end else begin
						ovf = 1'b1;
						r.status = acm_pkg::ST_FULL;
					end
				end
			end
			acm_pkg::OP_END_PATTERN: begin
				if (built) begin
					r.status = acm_pkg::ST_REJECT;
				end else if (ovf) begin
					ovf = 1'b0;
					icur = '0;
					r.status = acm_pkg::ST_FULL;
				end else begin
					if (pcount[icur] != acm_pkg::COUNT_MAX) pcount[icur]++;
					icur = '0;
				end
			end
			acm_pkg::OP_BUILD: begin
				if (built) begin
					r.status = acm_pkg::ST_REJECT;
				end else begin
					build_links();
					built = 1'b1;
					qcur = '0;
				end
			end
			acm_pkg::OP_QUERY: begin
				if (!built || sym >= acm_pkg::ALPHABET) begin
					r.status = acm_pkg::ST_REJECT;
				end else begin
					qcur = trans[int'(qcur) * acm_pkg::ALPHABET + int'(sym)];
					walk_chain(qcur);
				end
			end
			acm_pkg::OP_END_QUERY: begin
				if (!built) r.status = acm_pkg::ST_REJECT;
			end
			acm_pkg::OP_CLEAR: clear_trie();
			default: r.status = acm_pkg::ST_REJECT;
		endcase
		r.total = total;
		r.node = built ? ((op == acm_pkg::OP_END_QUERY) ? '0 : qcur) : icur;
		if (op == acm_pkg::OP_END_QUERY && built) begin
			qcur = '0;
			total = '0;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [acm_pkg::TOTAL_W-1:0] got,
		input logic [acm_pkg::TOTAL_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		resp_t want;
		if (!arst_n) begin
			clear_trie();
			expected_q.delete();
			errors = 0;
		end else begin
			if (req.valid && req.ready)
				expected_q.push_back(match_step(req.operation, req.symbol));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected word", acm_pkg::TOTAL_W'(rsp.status), '0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						report("status", acm_pkg::TOTAL_W'(rsp.status),
							acm_pkg::TOTAL_W'(want.status));
					if (rsp.match_total !== want.total)
						report("match_total", rsp.match_total, want.total);
					if (rsp.current_node !== want.node)
						report("current_node", acm_pkg::TOTAL_W'(rsp.current_node),
							acm_pkg::TOTAL_W'(want.node));
				end
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the matcher with directed words for every phase rule, then random
// trie loads, builds and query texts with bursty traffic and a stalling
// receiver; includes one node store overflow. The checker judges responses.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT = 4000000;
	localparam int N_ITEMS = 1950;
	localparam logic [acm_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [acm_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int n_items;
	int burst_left;
	int ready_pct = 100;

	acm_req_if req_ch ();
	acm_rsp_if rsp_ch ();

	aho_corasick_matcher_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	acm_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (($urandom_range(0, 299)) == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 75;
				2: ready_pct <= 40;
				default: ready_pct <= 10;
			endcase
		end
		rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
	end

	task automatic send_word(input logic [acm_pkg::OP_W-1:0] op,
		input logic [acm_pkg::SYM_W-1:0] sym);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.symbol <= sym;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		n_items++;
	endtask

	task automatic send_noisy(input logic [acm_pkg::OP_W-1:0] op,
		input logic [acm_pkg::SYM_W-1:0] sym);
		if ($urandom_range(0, 19) == 0)
			send_word(acm_pkg::OP_W'($urandom_range(0, 7)),
				acm_pkg::SYM_W'($urandom_range(0, 31)));
		else
			send_word(op, sym);
	endtask

	task automatic random_phase(input bit overflow);
		int amax;
		amax = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 25) : $urandom_range(1, 3);
		send_word(acm_pkg::OP_CLEAR, acm_pkg::SYM_W'($urandom_range(0, 31)));
		if (overflow) begin
			for (int k = 0; k < acm_pkg::MAX_NODES + 6; k++)
				send_word(acm_pkg::OP_INSERT, acm_pkg::SYM_W'($urandom_range(0, 25)));
			send_word(acm_pkg::OP_END_PATTERN, '0);
			send_word(acm_pkg::OP_INSERT, acm_pkg::SYM_W'($urandom_range(0, 25)));
			send_word(acm_pkg::OP_END_PATTERN, '0);
		end
		repeat ($urandom_range(1, 10)) begin
			repeat ($urandom_range(0, 6))
				send_noisy(acm_pkg::OP_INSERT, acm_pkg::SYM_W'($urandom_range(0, amax)));
			send_noisy(acm_pkg::OP_END_PATTERN, acm_pkg::SYM_W'($urandom_range(0, 31)));
		end
		send_word(acm_pkg::OP_BUILD, acm_pkg::SYM_W'($urandom_range(0, 31)));
		repeat ($urandom_range(2, 8)) begin
			repeat ($urandom_range(1, 30))
				send_noisy(acm_pkg::OP_QUERY, acm_pkg::SYM_W'($urandom_range(0, amax)));
			send_noisy(acm_pkg::OP_END_QUERY, acm_pkg::SYM_W'($urandom_range(0, 31)));
		end
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= acm_pkg::OP_INSERT;
		req_ch.symbol <= '0;
		n_items = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_word(acm_pkg::OP_QUERY, 5'd0);
		send_word(acm_pkg::OP_END_QUERY, 5'd31);
		send_word(OP_UNUSED_LO, 5'd0);
		send_word(OP_UNUSED_HI, 5'd31);
		send_word(acm_pkg::OP_INSERT, 5'd26);
		send_word(acm_pkg::OP_INSERT, 5'd31);
		send_word(acm_pkg::OP_END_PATTERN, 5'd0);
		send_word(acm_pkg::OP_INSERT, 5'd0);
		send_word(acm_pkg::OP_INSERT, 5'd25);
		send_word(acm_pkg::OP_END_PATTERN, 5'd0);
		send_word(acm_pkg::OP_INSERT, 5'd25);
		send_word(acm_pkg::OP_END_PATTERN, 5'd0);
		send_word(acm_pkg::OP_BUILD, 5'd0);
		send_word(acm_pkg::OP_BUILD, 5'd0);
		send_word(acm_pkg::OP_INSERT, 5'd1);
		send_word(acm_pkg::OP_END_PATTERN, 5'd0);
		send_word(acm_pkg::OP_QUERY, 5'd0);
		send_word(acm_pkg::OP_QUERY, 5'd25);
		send_word(acm_pkg::OP_QUERY, 5'd25);
		send_word(acm_pkg::OP_QUERY, 5'd31);
		send_word(acm_pkg::OP_QUERY, 5'd26);
		send_word(acm_pkg::OP_END_QUERY, 5'd0);
		send_word(acm_pkg::OP_QUERY, 5'd25);
		send_word(acm_pkg::OP_END_QUERY, 5'd0);

		phase = 0;
		while (n_items < N_ITEMS) begin
			random_phase(phase == 2);
			phase++;
		end
		req_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/acm_pkg.sv
sv/acm_req_if.sv
sv/acm_rsp_if.sv
sv/acm_dpath.sv
sv/acm_ctrl.sv
sv/aho_corasick_matcher_core.sv
tb/acm_checker.sv
tb/testbench.sv
